/* sv/pgmsp_pkg.sv */
// Package for the PGM stream parser: item types, parse phases, result and error codes.
// Used by pgmsp_outq and pgm_stream_parser. No dependencies.
`default_nettype none

package pgmsp_pkg;

    // Default width of parsed numbers and position counters
    localparam int VALUE_BITS_DEF = 16;

    // Result queue depth (one item may produce two results)
    localparam int OUTQ_DEPTH = 4;

    // ASCII codes the parser looks for
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_5    = 8'h35;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;

    typedef enum logic [3:0] {
        PH_MAGIC_P,
        PH_MAGIC_NUM,
        PH_WS_W,
        PH_CMT_W,
        PH_NUM_W,
        PH_WS_H,
        PH_CMT_H,
        PH_NUM_H,
        PH_WS_M,
        PH_CMT_M,
        PH_NUM_M,
        PH_PIX_WS,
        PH_PIX_NUM,
        PH_PIX_BIN,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_PIXEL,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        ERR_BAD_MAGIC,
        ERR_CORRUPT,
        ERR_ZERO_WIDTH,
        ERR_ZERO_HEIGHT,
        ERR_TOO_LARGE,
        ERR_TRUNCATED
    } t_err;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] max_value;
        logic [15:0] pixel_value;
        logic [15:0] column;
        logic [15:0] row;
        logic        last_pixel;
        t_err        error_code;
    } t_res_item;

    // Results written into the queue in the same cycle, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_res_item  first;
        t_res_item  second;
    } t_push;

endpackage

`default_nettype wire

/* sv/pgmsp_outq.sv */
// Result queue of the PGM stream parser: takes up to two results a cycle, hands out one when i_ready is high.
// Depends on pgmsp_pkg.
`default_nettype none

module pgmsp_outq
    import pgmsp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_push     i_push,
    output logic           o_room,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_res_item      o_item
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_res_item r_mem [OUTQ_DEPTH];

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign pop     = (r_count != '0) && i_ready;
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rp];
    // Room for a worst-case item (two results)
    assign o_room  = (r_count <= CNT_W'(OUTQ_DEPTH - 2));

    // Pointer and fill count update
    always_comb begin
        n_wp    = r_wp + PTR_W'(i_push.cnt);
        n_rp    = pop ? r_rp + PTR_W'(1) : r_rp;
        n_count = r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + PTR_W'(1)] <= i_push.second;
        end
    end

endmodule

`default_nettype wire

/* sv/pgm_stream_parser.sv */
// PGM (P2/P5) byte stream parser, top level: input register, parse state, result queue.
// Depends on pgmsp_pkg and pgmsp_outq.
//
//  Channel  Direction  Handshake                      Payload
//  byte     in         i_byte_valid / o_byte_ready    i_byte_item (t_in_item)
//  result   out        o_res_valid / i_res_ready      o_res_item (t_res_item)
//
// One byte item per cycle is accepted while the result queue has room for two; else the input stalls.
// A result is offered once its item has passed the input register and been written into the queue;
// a queue without room holds the item in the input register.
// The four-entry result queue gates the input: an item leaves the input register only while the queue
// holds two or fewer results, so an item that gives two results uses two queue entries.
// Reset (synchronous, active low) returns the parser to expecting the magic and empties
// the queue. Stalls on the result side back up through the queue to o_byte_ready.
`default_nettype none

module pgm_stream_parser
    import pgmsp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_byte_valid,
    output logic           o_byte_ready,
    input  wire t_in_item  i_byte_item,
    output logic           o_res_valid,
    input  wire logic      i_res_ready,
    output t_res_item      o_res_item
);

    localparam int VB = VALUE_BITS;

    // Low 16 bits of a stored value, zero-extended when narrower
    function automatic logic [15:0] to16(input logic [VB-1:0] x);
        logic [VB+15:0] ext;
        ext = {16'b0, x};
        return ext[15:0];
    endfunction

    // Input register
    logic     r_in_valid;
    t_in_item r_in;
    logic     step_fire;
    logic     q_room;

    // Parse state
    t_phase        r_phase, n_phase;
    logic          r_binary, n_binary;
    logic [VB-1:0] r_acc, n_acc;
    logic [VB-1:0] r_width, n_width;
    logic [VB-1:0] r_height, n_height;
    logic [VB-1:0] r_gray, n_gray;
    logic [VB-1:0] r_col, n_col;
    logic [VB-1:0] r_row, n_row;

    // Step helpers
    logic [7:0]    b;
    logic          eos;
    logic          is_white;
    logic          is_digit;
    logic [7:0]    dsub;
    logic [VB+3:0] acc_ext;
    logic [VB+3:0] acc_sum;
    logic          acc_ovf;
    logic [VB:0]   col_p1;
    logic [VB:0]   row_p1;
    logic          col_wrap;
    logic          row_end;
    logic          pix_last;

    logic          emit_hdr;
    logic          emit_pix;
    logic          emit_err;
    t_err          err_code;
    logic [VB-1:0] pix_val;

    t_res_item     res_pix, res_hdr, res_err;
    t_push         push;

    assign step_fire    = r_in_valid && q_room;
    assign o_byte_ready = !r_in_valid || step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_byte_ready) begin
            r_in_valid <= i_byte_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_byte_ready && i_byte_valid) begin
            r_in <= i_byte_item;
        end
    end

    // Byte classification and arithmetic
    assign b        = r_in.byte_value;
    assign eos      = r_in.end_of_stream;
    assign is_white = b inside {CH_SP, [CH_TAB:CH_CR]};
    assign is_digit = b inside {[CH_0:CH_9]};
    assign dsub     = b - CH_0;
    assign acc_ext  = {4'b0, r_acc};
    assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + {{VB{1'b0}}, dsub[3:0]};
    assign acc_ovf  = |acc_sum[VB+3:VB];
    assign col_p1   = {1'b0, r_col} + (VB+1)'(1);
    assign row_p1   = {1'b0, r_row} + (VB+1)'(1);
    assign col_wrap = (col_p1 >= {1'b0, r_width});
    assign row_end  = (row_p1 >= {1'b0, r_height});
    assign pix_last = col_wrap && row_end;

    // Next state and emitted results
    always_comb begin
        n_phase  = r_phase;
        n_binary = r_binary;
        n_acc    = r_acc;
        n_width  = r_width;
        n_height = r_height;
        n_gray   = r_gray;
        n_col    = r_col;
        n_row    = r_row;
        emit_hdr = 1'b0;
        emit_pix = 1'b0;
        emit_err = 1'b0;
        err_code = ERR_BAD_MAGIC;
        pix_val  = r_acc;

        if (eos) begin
            if (r_phase == PH_PIX_NUM) begin
                emit_pix = 1'b1;
                emit_err = !pix_last;
                err_code = ERR_TRUNCATED;
            end else if (r_phase != PH_MAGIC_P && r_phase != PH_DONE &&
                         r_phase != PH_ERROR) begin
                emit_err = 1'b1;
                err_code = ERR_TRUNCATED;
            end
        end else begin
            case (r_phase)
                PH_MAGIC_P: begin
                    if (b == CH_P) begin
                        n_phase = PH_MAGIC_NUM;
                    end else begin
                        emit_err = 1'b1;
                        err_code = ERR_BAD_MAGIC;
                    end
                end
                PH_MAGIC_NUM: begin
                    if (b == CH_2) begin
                        n_binary = 1'b0;
                        n_phase  = PH_WS_W;
                    end else if (b == CH_5) begin
                        n_binary = 1'b1;
                        n_phase  = PH_WS_W;
                    end else begin
                        emit_err = 1'b1;
                        err_code = ERR_BAD_MAGIC;
                    end
                end
                PH_WS_W, PH_WS_H, PH_WS_M: begin
                    if (is_white) begin
                        n_phase = r_phase;
                    end else if (b == CH_HASH) begin
                        n_phase = t_phase'(r_phase + 4'd1);
                    end else if (is_digit) begin
                        n_acc   = {{(VB-4){1'b0}}, dsub[3:0]};
                        n_phase = t_phase'(r_phase + 4'd2);
                    end else begin
                        emit_err = 1'b1;
                        err_code = ERR_CORRUPT;
                    end
                end
                PH_CMT_W, PH_CMT_H, PH_CMT_M: begin
                    if (b == CH_LF || b == CH_CR) begin
                        n_phase = t_phase'(r_phase - 4'd1);
                    end
                end
                PH_NUM_W, PH_NUM_H: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            emit_err = 1'b1;
                            err_code = ERR_TOO_LARGE;
                        end else begin
                            n_acc = acc_sum[VB-1:0];
                        end
                    end else begin
                        if (r_phase == PH_NUM_W) begin
                            n_width = r_acc;
                        end else begin
                            n_height = r_acc;
                        end
                        n_acc = '0;
                        if (r_acc == '0) begin
                            emit_err = 1'b1;
                            err_code = (r_phase == PH_NUM_W) ? ERR_ZERO_WIDTH
                                                             : ERR_ZERO_HEIGHT;
                        end else if (is_white) begin
                            n_phase = t_phase'(r_phase + 4'd1);
                        end else if (b == CH_HASH) begin
                            n_phase = t_phase'(r_phase + 4'd2);
                        end else begin
                            emit_err = 1'b1;
                            err_code = ERR_CORRUPT;
                        end
                    end
                end
                PH_NUM_M: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            emit_err = 1'b1;
                            err_code = ERR_TOO_LARGE;
                        end else begin
                            n_acc = acc_sum[VB-1:0];
                        end
                    end else begin
                        n_gray = r_acc;
                        n_acc  = '0;
                        if (!is_white) begin
                            emit_err = 1'b1;
                            err_code = ERR_CORRUPT;
                        end else begin
                            emit_hdr = 1'b1;
                            n_col    = '0;
                            n_row    = '0;
                            n_phase  = r_binary ? PH_PIX_BIN : PH_PIX_WS;
                        end
                    end
                end
                PH_PIX_WS: begin
                    if (is_white) begin
                        n_phase = r_phase;
                    end else if (is_digit) begin
                        n_acc   = {{(VB-4){1'b0}}, dsub[3:0]};
                        n_phase = PH_PIX_NUM;
                    end else begin
                        emit_err = 1'b1;
                        err_code = ERR_CORRUPT;
                    end
                end
                PH_PIX_NUM: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            emit_err = 1'b1;
                            err_code = ERR_TOO_LARGE;
                        end else begin
                            n_acc = acc_sum[VB-1:0];
                        end
                    end else begin
                        n_acc    = '0;
                        emit_pix = 1'b1;
                        if (!pix_last) begin
                            if (is_white) begin
                                n_phase = PH_PIX_WS;
                            end else begin
                                emit_err = 1'b1;
                                err_code = ERR_CORRUPT;
                            end
                        end
                    end
                end
                PH_PIX_BIN: begin
                    emit_pix = 1'b1;
                    pix_val  = {{(VB-8){1'b0}}, b};
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        // Raster position after a pixel
        if (emit_pix) begin
            if (pix_last) begin
                n_phase = PH_DONE;
            end else if (col_wrap) begin
                n_col = '0;
                n_row = row_p1[VB-1:0];
            end else begin
                n_col = col_p1[VB-1:0];
            end
        end

        if (emit_err) begin
            n_phase = PH_ERROR;
        end

        // End of stream puts everything back to its reset value
        if (eos) begin
            n_phase  = PH_MAGIC_P;
            n_binary = 1'b0;
            n_acc    = '0;
            n_width  = '0;
            n_height = '0;
            n_gray   = '0;
            n_col    = '0;
            n_row    = '0;
        end
    end

    // Result items; header values are those after this step's updates (before it, on end of stream)
    always_comb begin
        res_hdr.kind        = KIND_HEADER;
        res_hdr.width       = to16(eos ? r_width : n_width);
        res_hdr.height      = to16(eos ? r_height : n_height);
        res_hdr.max_value   = to16(eos ? r_gray : n_gray);
        res_hdr.pixel_value = '0;
        res_hdr.column      = '0;
        res_hdr.row         = '0;
        res_hdr.last_pixel  = 1'b0;
        res_hdr.error_code  = ERR_BAD_MAGIC;

        res_pix             = res_hdr;
        res_pix.kind        = KIND_PIXEL;
        res_pix.pixel_value = to16(pix_val);
        res_pix.column      = to16(r_col);
        res_pix.row         = to16(r_row);
        res_pix.last_pixel  = pix_last;

        res_err             = res_hdr;
        res_err.kind        = KIND_ERROR;
        res_err.error_code  = err_code;

        push.cnt    = 2'd0;
        push.first  = res_err;
        push.second = res_err;
        if (step_fire) begin
            push.cnt = 2'(emit_hdr) + 2'(emit_pix) + 2'(emit_err);
            if (emit_pix) begin
                push.first = res_pix;
            end else if (emit_hdr) begin
                push.first = res_hdr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC_P;
            r_binary <= 1'b0;
            r_acc    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_gray   <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (step_fire) begin
            r_phase  <= n_phase;
            r_binary <= n_binary;
            r_acc    <= n_acc;
            r_width  <= n_width;
            r_height <= n_height;
            r_gray   <= n_gray;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    pgmsp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (q_room),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_item  (o_res_item)
    );

    // Once in error, only end of stream leaves it
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |=> (r_phase == PH_ERROR || r_phase == PH_MAGIC_P))
        else $error("error phase left without end of stream");

    // End of stream always restarts the parse
    a_eos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && r_in.end_of_stream) |=> (r_phase == PH_MAGIC_P && r_col == '0))
        else $error("end of stream did not restart the parser");

    // Pixel position stays inside the image
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIX_WS || r_phase == PH_PIX_NUM || r_phase == PH_PIX_BIN)
        |-> (r_col < r_width && r_row < r_height))
        else $error("pixel position outside image");

    // A step only pushes results with room for two in the queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0) |-> q_room)
        else $error("result queue written without room");

endmodule

`default_nettype wire
